>>> hw/rtl/itp_pkg.sv
// shared types, codes and helpers for the infix to postfix converter
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

    // input token kinds
    localparam logic [2:0] TK_NUMBER = 3'd0;
    localparam logic [2:0] TK_OPER   = 3'd1;
    localparam logic [2:0] TK_OPEN   = 3'd2;
    localparam logic [2:0] TK_CLOSE  = 3'd3;
    localparam logic [2:0] TK_END    = 3'd4;

    // operator codes
    localparam logic [3:0] OP_PLUS    = 4'd0;
    localparam logic [3:0] OP_MINUS   = 4'd1;
    localparam logic [3:0] OP_TIMES   = 4'd2;
    localparam logic [3:0] OP_DIVIDE  = 4'd3;
    localparam logic [3:0] OP_POWER   = 4'd4;
    localparam logic [3:0] OP_LAST    = 4'd8;
    localparam logic [3:0] PAREN_MARK = 4'd15;

    // result kinds
    localparam logic [1:0] OK_NUMBER = 2'd0;
    localparam logic [1:0] OK_OPER   = 2'd1;
    localparam logic [1:0] OK_ERROR  = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_PAREN    = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC
    } t_state;

    // datapath to controller
    typedef struct packed {
        logic is_num;
        logic is_op;
        logic is_open;
        logic is_close;
        logic is_end;
        logic op_known;
        logic op_pow;
        logic empty;
        logic single;
        logic full;
        logic paren_any;
        logic top_paren;
        logic below_paren;
        logic top_stop;
        logic below_stop;
        logic out_free;
    } t_dp_status;

    // controller to datapath
    typedef struct packed {
        logic       latch;
        logic       emit;
        logic [1:0] emit_kind;
        logic [1:0] err_code;
        logic       last;
        logic       pop;
        logic       push;
        logic       push_paren;
        logic       clear;
    } t_dp_cmd;

    function automatic logic [1:0] prec_of(input logic [3:0] op);
        logic [1:0] p;
        p = 2'd0;
        if (op == OP_PLUS || op == OP_MINUS) begin
            p = 2'd1;
        end else if (op == OP_TIMES || op == OP_DIVIDE) begin
            p = 2'd2;
        end else if (op == OP_POWER) begin
            p = 2'd3;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/itp_ctrl.sv
// controller state machine of the infix to postfix converter
`timescale 1ns / 1ps
`default_nettype none

module itp_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire itp_pkg::t_dp_status i_status,
    output itp_pkg::t_dp_cmd        o_cmd
);
    import itp_pkg::*;

    t_state r_state, n_state;
    logic   w_exec_done;
    logic   w_exec_loop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        w_exec_done = 1'b0;
        w_exec_loop = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            S_FETCH: begin
            end
            S_EXEC: begin
                if (i_status.is_num) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = OK_NUMBER;
                    o_cmd.last      = 1'b1;
                    w_exec_done     = 1'b1;
                end else if (i_status.is_op && i_status.op_known) begin
                    if (!i_status.op_pow && !i_status.empty && !i_status.top_stop) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = OK_OPER;
                        o_cmd.last      = i_status.single || i_status.below_stop;
                        o_cmd.pop       = 1'b1;
                        w_exec_loop     = 1'b1;
                    end else if (i_status.full) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = OK_ERROR;
                        o_cmd.err_code  = ERR_OVERFLOW;
                        o_cmd.last      = 1'b1;
                        o_cmd.clear     = 1'b1;
                        w_exec_done     = 1'b1;
                    end else begin
                        o_cmd.push  = 1'b1;
                        w_exec_done = 1'b1;
                    end
                end else if (i_status.is_open) begin
                    if (i_status.full) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = OK_ERROR;
                        o_cmd.err_code  = ERR_OVERFLOW;
                        o_cmd.last      = 1'b1;
                        o_cmd.clear     = 1'b1;
                    end else begin
                        o_cmd.push       = 1'b1;
                        o_cmd.push_paren = 1'b1;
                    end
                    w_exec_done = 1'b1;
                end else if (i_status.is_close) begin
                    if (!i_status.paren_any) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = OK_ERROR;
                        o_cmd.err_code  = ERR_PAREN;
                        o_cmd.last      = 1'b1;
                        o_cmd.clear     = 1'b1;
                        w_exec_done     = 1'b1;
                    end else if (i_status.top_paren) begin
                        o_cmd.pop   = 1'b1;
                        w_exec_done = 1'b1;
                    end else begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = OK_OPER;
                        o_cmd.last      = i_status.below_paren;
                        o_cmd.pop       = 1'b1;
                        w_exec_loop     = 1'b1;
                    end
                end else if (i_status.is_end) begin
                    if (i_status.paren_any) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = OK_ERROR;
                        o_cmd.err_code  = ERR_PAREN;
                        o_cmd.last      = 1'b1;
                        o_cmd.clear     = 1'b1;
                        w_exec_done     = 1'b1;
                    end else if (i_status.empty) begin
                        w_exec_done = 1'b1;
                    end else begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = OK_OPER;
                        o_cmd.last      = i_status.single;
                        o_cmd.pop       = 1'b1;
                        w_exec_loop     = 1'b1;
                    end
                end else begin
                    w_exec_done = 1'b1;
                end
                // hold everything while the output register is occupied
                if (o_cmd.emit && !i_status.out_free) begin
                    o_cmd       = '0;
                    w_exec_done = 1'b0;
                    w_exec_loop = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_exec_loop) begin
                    n_state = S_FETCH;
                end else if (w_exec_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/itp_datapath.sv
// operator stack, token registers and output register of the converter
`timescale 1ns / 1ps
`default_nettype none

module itp_datapath #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [2:0]          i_token_kind,
    input  wire logic [3:0]          i_operator_code,
    input  wire logic [63:0]         i_number_value,
    input  wire logic                i_out_ready,
    input  wire itp_pkg::t_dp_cmd    i_cmd,
    output itp_pkg::t_dp_status      o_status,
    output logic                     o_out_valid,
    output logic [1:0]               o_out_kind,
    output logic [3:0]               o_out_operator,
    output logic [63:0]              o_out_value,
    output logic [1:0]               o_error_code,
    output logic                     o_last_of_run
);
    import itp_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    logic [3:0]    r_stack [STACK_DEPTH];
    logic [3:0]    r_rd_data;
    logic [3:0]    r_top;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_paren_cnt;
    logic [2:0]    r_kind;
    logic [3:0]    r_op;
    logic [63:0]   r_value;

    logic [CW-1:0] w_below_idx;
    logic [3:0]    w_push_val;
    logic [1:0]    w_prec;
    logic          w_out_free;

    assign w_below_idx = r_count - TWO_C;
    assign w_push_val  = i_cmd.push_paren ? PAREN_MARK : r_op;
    assign w_prec      = prec_of(r_op);
    assign w_out_free  = !o_out_valid || i_out_ready;

    // stack memory: one write port, one registered read of the entry under the top
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stack[r_count[AW-1:0]] <= w_push_val;
        end
        r_rd_data <= r_stack[w_below_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_paren_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_count     <= '0;
            r_paren_cnt <= '0;
        end else if (i_cmd.push) begin
            r_count <= r_count + ONE_C;
            if (i_cmd.push_paren) begin
                r_paren_cnt <= r_paren_cnt + ONE_C;
            end
        end else if (i_cmd.pop) begin
            r_count <= r_count - ONE_C;
            if (r_top == PAREN_MARK) begin
                r_paren_cnt <= r_paren_cnt - ONE_C;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_top <= w_push_val;
        end else if (i_cmd.pop) begin
            r_top <= r_rd_data;
        end
        if (i_cmd.latch) begin
            r_kind  <= i_token_kind;
            r_op    <= i_operator_code;
            r_value <= i_number_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_out_kind     <= i_cmd.emit_kind;
            o_out_operator <= (i_cmd.emit_kind == OK_OPER) ? r_top : 4'd0;
            o_out_value    <= (i_cmd.emit_kind == OK_NUMBER) ? r_value : 64'd0;
            o_error_code   <= (i_cmd.emit_kind == OK_ERROR) ? i_cmd.err_code : ERR_NONE;
            o_last_of_run  <= i_cmd.last;
        end
    end

    always_comb begin
        o_status             = '0;
        o_status.is_num      = (r_kind == TK_NUMBER);
        o_status.is_op       = (r_kind == TK_OPER);
        o_status.is_open     = (r_kind == TK_OPEN);
        o_status.is_close    = (r_kind == TK_CLOSE);
        o_status.is_end      = (r_kind == TK_END);
        o_status.op_known    = (r_op <= OP_LAST);
        o_status.op_pow      = (r_op == OP_POWER);
        o_status.empty       = (r_count == '0);
        o_status.single      = (r_count == ONE_C);
        o_status.full        = (r_count >= DEPTH_C);
        o_status.paren_any   = (r_paren_cnt != '0);
        o_status.top_paren   = (r_top == PAREN_MARK);
        o_status.below_paren = (r_rd_data == PAREN_MARK);
        o_status.top_stop    = (r_top == PAREN_MARK) || (prec_of(r_top) < w_prec);
        o_status.below_stop  = (r_rd_data == PAREN_MARK) || (prec_of(r_rd_data) < w_prec);
        o_status.out_free    = w_out_free;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("stack count beyond depth");

    a_paren_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_paren_cnt <= r_count)
        else $error("more parens counted than stack entries");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> w_out_free)
        else $error("result written over an untaken transaction");

    a_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.push && (i_cmd.pop || i_cmd.clear)))
        else $error("push together with pop or clear");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (r_count < DEPTH_C))
        else $error("push onto a full stack");

endmodule

`default_nettype wire

>>> hw/rtl/infix_to_postfix_converter_top.sv
// top level of the shunting-yard infix to postfix converter
`timescale 1ns / 1ps
`default_nettype none

// shunting-yard converter: one token per input transaction, postfix tokens out.
// numbers pass straight through; operators pop stacked operators of equal or
// higher precedence (^ is right associative and never pops), a close paren pops
// down to its open paren, and the end marker drains the stack. an unmatched
// paren or a push onto a full stack gives a single error transaction and clears
// the stack. last_of_run marks the final result of each input token.
// timing: one token is worked on at a time. a token without pops passes through
// accept, stack read and execute; every operator popped to the output repeats the
// stack read and execute, since each such pop waits for the single registered read
// port of the stack memory to deliver the entry beneath the top. the open paren that
// ends a close paren is discarded in the execute step with no further stack read.
// stalls on the output side lengthen this.
// the result register lets the next token be accepted while the last result
// is still waiting to be taken.
module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // token input channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_token_kind,
    input  wire logic [3:0]  i_operator_code,
    input  wire logic [63:0] i_number_value,
    // postfix result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_out_kind,
    output logic [3:0]       o_out_operator,
    output logic [63:0]      o_out_value,
    output logic [1:0]       o_error_code,
    output logic             o_last_of_run
);
    import itp_pkg::*;

    t_dp_status w_status;
    t_dp_cmd    w_cmd;

    // sequencing: accept, read the entry under the top, decide and act
    itp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // operator stack, latched token and result register
    itp_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_token_kind    (i_token_kind),
        .i_operator_code (i_operator_code),
        .i_number_value  (i_number_value),
        .i_out_ready     (i_out_ready),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_out_valid     (o_out_valid),
        .o_out_kind      (o_out_kind),
        .o_out_operator  (o_out_operator),
        .o_out_value     (o_out_value),
        .o_error_code    (o_error_code),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

`default_nettype wire

>>> tb/sv/infix_to_postfix_converter_top_tb.sv
// self-checking testbench for the shunting-yard infix to postfix converter
`timescale 1ns / 1ps

module infix_to_postfix_converter_top_tb;
    import itp_pkg::*;

    localparam int DEPTH       = 16;
    localparam int ITEMS       = 430;
    // receiver hold-off long enough to back the block up into its input
    localparam int HOLD_CYCLES = 300;
    // cycles without any transaction before the run is declared hung
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 40;

    // operator codes the package does not name
    localparam logic [3:0] OP_MOD   = 4'd5;
    localparam logic [3:0] OP_AND   = 4'd6;
    localparam logic [3:0] OP_OR    = 4'd7;
    localparam logic [3:0] OP_UNDER = 4'd8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_token_kind = '0;
    logic [3:0]  i_operator_code = '0;
    logic [63:0] i_number_value = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_out_kind;
    logic [3:0]  o_out_operator;
    logic [63:0] o_out_value;
    logic [1:0]  o_error_code;
    logic        o_last_of_run;

    // one postfix result as the block should present it
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  oper;
        logic [63:0] value;
        logic [1:0]  err;
        logic        last;
    } t_postfix;

    t_postfix   postfix_q[$];        // postfix results still owed by the block
    logic [3:0] op_stack[DEPTH];     // mirror of the operator stack
    int         op_depth = 0;
    int         n_fail = 0;
    int         n_tokens = 0;        // accepted tokens that the block acts on
    int         stall_cycles = 0;
    bit         tx_calm = 1'b0;      // sender sends back to back while set
    bit         hold_req = 1'b0;     // asks the receiver for a long hold-off

    infix_to_postfix_converter_top #(
        .STACK_DEPTH(DEPTH)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_token_kind(i_token_kind),
        .i_operator_code(i_operator_code),
        .i_number_value(i_number_value),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_kind(o_out_kind),
        .o_out_operator(o_out_operator),
        .o_out_value(o_out_value),
        .o_error_code(o_error_code),
        .o_last_of_run(o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // shunting-yard predictor
    // ------------------------------------------------------------------

    function automatic int bind_level(input logic [3:0] op);
        case (op)
            OP_PLUS, OP_MINUS:  return 1;
            OP_TIMES, OP_DIVIDE: return 2;
            OP_POWER:           return 3;
            default:            return 0;
        endcase
    endfunction

    function automatic bit paren_pending();
        for (int i = 0; i < op_depth; i++) begin
            if (op_stack[i] == PAREN_MARK) return 1'b1;
        end
        return 1'b0;
    endfunction

    // works out the postfix results of one accepted token
    function automatic void shunt_token(input logic [2:0] kind, input logic [3:0] op,
                                        input logic [63:0] val);
        t_postfix   run[$];
        t_postfix   r;
        logic [3:0] top;
        bit         overflow;
        bit         mismatch;
        overflow = 1'b0;
        mismatch = 1'b0;
        r = '0;
        case (kind)
            TK_NUMBER: begin
                r.kind  = OK_NUMBER;
                r.value = val;
                run = {run, r};
            end
            TK_OPER: begin
                if (op <= OP_LAST) begin
                    // right-associative power never pops
                    if (op != OP_POWER) begin
                        while (op_depth > 0) begin
                            top = op_stack[op_depth - 1];
                            if (top == PAREN_MARK || bind_level(top) < bind_level(op)) break;
                            r.kind = OK_OPER;
                            r.oper = top;
                            run = {run, r};
                            op_depth--;
                        end
                    end
                    if (op_depth >= DEPTH) begin
                        overflow = 1'b1;
                    end else begin
                        op_stack[op_depth] = op;
                        op_depth++;
                    end
                end
            end
            TK_OPEN: begin
                if (op_depth >= DEPTH) begin
                    overflow = 1'b1;
                end else begin
                    op_stack[op_depth] = PAREN_MARK;
                    op_depth++;
                end
            end
            TK_CLOSE: begin
                if (!paren_pending()) begin
                    mismatch = 1'b1;
                end else begin
                    while (op_depth > 0) begin
                        top = op_stack[op_depth - 1];
                        op_depth--;
                        if (top == PAREN_MARK) break;
                        r.kind = OK_OPER;
                        r.oper = top;
                        run = {run, r};
                    end
                end
            end
            TK_END: begin
                if (paren_pending()) begin
                    mismatch = 1'b1;
                end else begin
                    while (op_depth > 0) begin
                        op_depth--;
                        r.kind = OK_OPER;
                        r.oper = op_stack[op_depth];
                        run = {run, r};
                    end
                end
            end
            default: ;
        endcase
        // an error replaces anything popped and empties the stack
        if (overflow || mismatch) begin
            op_depth = 0;
            run.delete();
            r = '0;
            r.kind = OK_ERROR;
            r.err  = overflow ? ERR_OVERFLOW : ERR_PAREN;
            run = {run, r};
        end
        if (run.size() > 0) run[run.size() - 1].last = 1'b1;
        postfix_q = {postfix_q, run};
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly short gaps, now and then a long one
    function automatic int rand_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // offers one token at the falling edge and holds it until the transaction;
    // leaves valid high when no gap follows so the next token goes out at once
    task automatic send_token(input logic [2:0] kind, input logic [3:0] op,
                              input logic [63:0] val);
        int gap;
        i_in_valid      = 1'b1;
        i_token_kind    = kind;
        i_operator_code = op;
        i_number_value  = val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        shunt_token(kind, op, val);
        if (kind <= TK_END && !(kind == TK_OPER && op > OP_LAST)) n_tokens++;
        @(negedge i_clk);
        gap = tx_calm ? 0 : rand_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_number();
        send_token(TK_NUMBER, OP_PLUS, rand_value());
    endtask

    task automatic send_op(input logic [3:0] op);
        send_token(TK_OPER, op, rand_value());
    endtask

    // sender pause until every owed result has come out
    task automatic wait_postfix_drained();
        i_in_valid = 1'b0;
        wait (postfix_q.size() == 0);
        @(negedge i_clk);
    endtask

    task automatic send_expr(input int level);
        int n_ops;
        n_ops = $urandom_range(0, 4);
        send_operand(level);
        repeat (n_ops) begin
            send_op(4'($urandom_range(0, OP_LAST)));
            send_operand(level);
        end
    endtask

    task automatic send_operand(input int level);
        if (level < 4 && $urandom_range(0, 3) == 0) begin
            send_token(TK_OPEN, OP_PLUS, rand_value());
            send_expr(level + 1);
            send_token(TK_CLOSE, OP_PLUS, rand_value());
        end else begin
            send_number();
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // payload extremes pass through; end marker on an empty stack gives nothing
    task automatic test_numbers();
        send_token(TK_NUMBER, OP_PLUS, 64'h0);
        send_token(TK_NUMBER, OP_PLUS, '1);
        send_token(TK_NUMBER, OP_LAST, 64'hAAAA_AAAA_AAAA_AAAA);
        send_token(TK_NUMBER, PAREN_MARK, 64'h5555_5555_5555_5555);
        send_token(TK_END, OP_PLUS, '0);
    endtask

    // every operator, precedence order and right-associative power
    task automatic test_operators();
        send_number(); send_op(OP_PLUS); send_number(); send_op(OP_TIMES);
        send_number(); send_op(OP_POWER); send_number(); send_op(OP_POWER);
        send_number(); send_op(OP_MINUS); send_number();
        send_token(TK_END, OP_PLUS, '0);
        send_token(TK_OPEN, OP_PLUS, '0);
        send_number(); send_op(OP_DIVIDE); send_number();
        send_token(TK_CLOSE, OP_PLUS, '0);
        send_op(OP_MOD); send_number(); send_op(OP_AND); send_number();
        send_op(OP_OR); send_number(); send_op(OP_UNDER); send_number();
        send_token(TK_END, OP_PLUS, '0);
    endtask

    // unmatched parens in both directions; low-precedence ops stop at a paren
    task automatic test_parens();
        send_token(TK_CLOSE, OP_PLUS, '0);
        send_token(TK_OPEN, OP_PLUS, '0);
        send_number();
        send_token(TK_END, OP_PLUS, '0);
        send_token(TK_OPEN, OP_PLUS, '0);
        send_token(TK_OPEN, OP_PLUS, '0);
        send_number();
        send_token(TK_CLOSE, OP_PLUS, '0);
        send_token(TK_CLOSE, OP_PLUS, '0);
        send_token(TK_CLOSE, OP_PLUS, '0);
        send_token(TK_END, OP_PLUS, '0);
        send_op(OP_AND);
        send_token(TK_OPEN, OP_PLUS, '0);
        send_number(); send_op(OP_UNDER); send_number(); send_op(OP_MOD); send_number();
        send_token(TK_CLOSE, OP_PLUS, '0);
        send_op(OP_TIMES); send_number();
        send_token(TK_END, OP_PLUS, '0);
    endtask

    // unknown token kinds and operator codes are dropped without a result
    task automatic test_ignored();
        for (int k = TK_END + 1; k <= 7; k++) send_token(3'(k), OP_PLUS, rand_value());
        send_op(OP_TIMES);
        for (int c = OP_LAST + 1; c <= PAREN_MARK; c++) send_op(4'(c));
        send_token(TK_END, OP_PLUS, '0);
    endtask

    // full stack: drain of every entry, then overflow by paren and by operator
    task automatic test_overflow();
        repeat (DEPTH) send_op(OP_POWER);
        send_token(TK_END, OP_PLUS, '0);
        repeat (DEPTH) send_token(TK_OPEN, OP_PLUS, '0);
        send_token(TK_OPEN, OP_PLUS, '0);
        repeat (DEPTH) send_op(OP_POWER);
        send_op(OP_POWER);
        repeat (DEPTH - 1) send_token(TK_OPEN, OP_PLUS, '0);
        send_op(OP_UNDER);
        send_op(OP_UNDER);
        send_token(TK_CLOSE, OP_PLUS, '0);
        send_token(TK_END, OP_PLUS, '0);
    endtask

    // receiver holds off while the sender keeps offering tokens back to back
    task automatic test_backpressure();
        tx_calm  = 1'b1;
        hold_req = 1'b1;
        send_number();
        repeat (12) begin
            send_op(4'($urandom_range(0, OP_LAST)));
            send_number();
        end
        send_token(TK_END, OP_PLUS, '0);
        tx_calm = 1'b0;
        wait (!hold_req);
    endtask

    // mostly well-formed expressions, some broken ones, some raw noise
    task automatic test_random();
        int pick;
        while (n_tokens < ITEMS) begin
            tx_calm = ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_expr(0);
                send_token(TK_END, OP_PLUS, rand_value());
            end else if (pick < 85) begin
                send_expr(0);
                case ($urandom_range(0, 2))
                    0: send_token(TK_CLOSE, OP_PLUS, rand_value());
                    1: begin
                        send_token(TK_OPEN, OP_PLUS, rand_value());
                        send_expr(1);
                    end
                    default: ;
                endcase
                if ($urandom_range(0, 1) == 0) send_token(TK_END, OP_PLUS, rand_value());
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_token(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                               rand_value());
                end
            end
        end
        tx_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        // synchronous reset held, then released on the falling edge
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_numbers();
        wait_postfix_drained();
        test_operators();
        wait_postfix_drained();
        test_parens();
        wait_postfix_drained();
        test_ignored();
        wait_postfix_drained();
        test_overflow();
        wait_postfix_drained();
        test_backpressure();
        wait_postfix_drained();
        test_random();

        // let the block finish everything it still owes, then settle
        wait_postfix_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // result receiver: random ready with calm stretches and one long hold-off
    // ------------------------------------------------------------------

    initial begin : out_sink
        int low_left;
        int calm_left;
        low_left  = 0;
        calm_left = 0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (low_left > 0) begin
                    i_out_ready = 1'b0;
                    low_left--;
                end else begin
                    i_out_ready = 1'b1;
                    if (calm_left > 0) begin
                        calm_left--;
                    end else if ($urandom_range(0, 29) == 0) begin
                        calm_left = $urandom_range(40, 150);
                    end else if ($urandom_range(0, 2) == 0) begin
                        low_left = rand_gap();
                    end
                end
                @(negedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // result checker: each result transaction against the oldest expectation
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge i_clk) begin : postfix_check
        t_postfix want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (postfix_q.size() == 0) begin
                $error("result transaction with nothing expected: kind %0d", o_out_kind);
                n_fail++;
            end else begin
                want = postfix_q.pop_front();
                check_field("out_kind", want.kind, o_out_kind);
                check_field("out_operator", want.oper, o_out_operator);
                check_field("out_value", want.value, o_out_value);
                check_field("error_code", want.err, o_error_code);
                check_field("last_of_run", want.last, o_last_of_run);
            end
        end
    end

    // hang detection: cycles in a row without a transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
